/* rtl/spc2d_pkg.sv */
// Shared types and codes for the same-padded 2D convolution stream.
`timescale 1ns / 1ps

package spc2d_pkg;

    // Request operation codes
    localparam logic [1:0] OP_COEF  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam int unsigned CFG_DW = 11;
    localparam int unsigned SUM_W  = 40;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_MAC,
        S_FL1,
        S_FL2,
        S_DONE
    } t_state;

endpackage

/* rtl/same_padded_conv2d_stream.sv */
// Top level of the same-padded 2D convolution stream.
`timescale 1ns / 1ps

// Streaming 2D correlation with zero padding to "same" size. After reset the
// block runs a clearing pass over all 2*MAX_KERNEL*MAX_WIDTH entries of the
// line store (14336 at the defaults) and holds o_in_stall high meanwhile. A
// coefficient request and a pixel or drain request that yields no output pass
// through the write state and return to idle. A request that yields an output
// pixel walks its side*side window (side = 2*radius+1) one tap per cycle
// through the single read port of the line store and the kernel table, into
// one 16x16 multiplier and a 40-bit accumulator. Results wait in an output
// register, so the next request is taken while a result is still stalled.
module same_padded_conv2d_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_KERNEL = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_op,
    input  logic signed [15:0]                i_pixel_value,
    input  logic [5:0]                        i_coef_index,
    input  logic signed [15:0]                i_coef_value,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [spc2d_pkg::SUM_W-1:0] o_sum_value,
    output logic                              o_frame_last,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [spc2d_pkg::CFG_DW-1:0]      i_cfg_data
);

    localparam int BUF_ROWS = 2 * MAX_KERNEL;
    localparam int LD       = BUF_ROWS * MAX_WIDTH;
    localparam int LAW      = $clog2(LD);
    localparam int BRW      = $clog2(BUF_ROWS);
    localparam int BMW      = BRW + 2;
    localparam int KD       = MAX_KERNEL * MAX_KERNEL;
    localparam int KAW      = (KD > 1) ? $clog2(KD) : 1;
    localparam int LIM      = (MAX_KERNEL - 1) / 2;
    localparam int KW       = $clog2(MAX_KERNEL + 1);
    localparam int SQW      = 2 * KW;
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int TW       = WW + HW;
    localparam int PW       = TW + 1;

    // configuration registers
    logic [spc2d_pkg::CFG_DW-1:0] r_cfg_w, r_cfg_h;
    logic [1:0]                   r_cfg_r;
    logic                         cfg_we;
    logic                         cfg_hit;

    // effective geometry
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [KW-1:0]  r_eff, side;
    logic [SQW-1:0] side_sq;
    logic [PW-1:0]  r_total, r_lag;

    // control
    spc2d_pkg::t_state r_state, n_state;
    logic [LAW-1:0]    r_clr;

    // latched request
    logic [1:0]         r_op;
    logic signed [15:0] r_pix, r_coef;
    logic [5:0]         r_cidx;

    // raster positions
    logic [PW-1:0]  r_pos;
    logic [CW-1:0]  r_in_col;
    logic [BRW-1:0] r_row_mod;
    logic [HW-1:0]  r_orow;
    logic [CW-1:0]  r_ocol;
    logic [BRW-1:0] r_orow_mod;
    logic           r_last;

    // window walk
    logic [KW-1:0]  r_i, r_j;
    logic [KAW-1:0] r_tap;
    logic           tap_last;

    // memories
    logic signed [15:0] line_mem [LD];
    logic signed [15:0] kern_mem [KD];
    logic signed [15:0] r_ls_q, r_k_q;
    logic               r_va;
    logic signed [31:0] r_prod;
    logic signed [spc2d_pkg::SUM_W-1:0] r_acc;

    // output register
    logic                               r_out_valid;
    logic signed [spc2d_pkg::SUM_W-1:0] r_sum;
    logic                               r_flast;

    // write-stage decode
    logic            in_frame, emit, is_last;
    logic [PW-1:0]   q;
    logic            ls_we, k_we;
    logic [LAW-1:0]  ls_waddr;
    logic signed [15:0] ls_wdata;
    logic [KAW-1:0]  k_waddr;

    // window address decode
    logic [HW:0]    rsum;
    logic [WW:0]    csum;
    logic [BMW-1:0] t_row, t_rowm;
    logic           tap_ok;
    logic [CW-1:0]  cc;
    logic [LAW-1:0] ls_raddr;

    logic out_take, out_load;

    assign cfg_we  = i_cfg_valid && o_cfg_ready;
    // only a listed register restarts the frame
    assign cfg_hit = cfg_we && ((i_cfg_index == spc2d_pkg::CFG_WIDTH)
                     || (i_cfg_index == spc2d_pkg::CFG_HEIGHT)
                     || (i_cfg_index == spc2d_pkg::CFG_RADIUS));

    // clamp the configured geometry
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
        if (32'(r_cfg_r) > 32'(LIM)) begin
            r_eff = KW'(LIM);
        end else begin
            r_eff = KW'(r_cfg_r);
        end
        side    = KW'({r_eff, 1'b1});
        side_sq = SQW'(side) * SQW'(side);
    end

    // derive frame size and output lag
    always_ff @(posedge i_clk) begin
        r_total <= PW'(w_eff) * PW'(h_eff);
        r_lag   <= PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= spc2d_pkg::CFG_DW'(1024);
            r_cfg_h <= spc2d_pkg::CFG_DW'(1024);
            r_cfg_r <= 2'd1;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                spc2d_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                spc2d_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                spc2d_pkg::CFG_RADIUS: r_cfg_r <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // decode the request in the write stage
    always_comb begin
        in_frame = r_pos < r_total;
        q        = r_pos - r_lag;
        emit     = (r_pos >= r_lag) && (q < r_total);
        is_last  = q == (r_total - PW'(1));
        ls_we    = 1'b0;
        k_we     = 1'b0;
        ls_waddr = LAW'(r_row_mod) * LAW'(MAX_WIDTH) + LAW'(r_in_col);
        ls_wdata = (r_op == spc2d_pkg::OP_PIXEL) ? r_pix : 16'sd0;
        k_waddr  = KAW'({2'b00, r_cidx});
        if (r_state == spc2d_pkg::S_CLEAR) begin
            ls_we    = 1'b1;
            ls_waddr = r_clr;
            ls_wdata = 16'sd0;
        end else if (r_state == spc2d_pkg::S_WRITE) begin
            k_we  = (r_op == spc2d_pkg::OP_COEF) && (SQW'(r_cidx) < side_sq)
                    && (8'(r_cidx) < 8'(side_sq));
            ls_we = ((r_op == spc2d_pkg::OP_PIXEL) || (r_op == spc2d_pkg::OP_DRAIN))
                    && in_frame;
        end
    end

    // map the current tap to a line store entry
    always_comb begin
        rsum  = (HW + 1)'(r_orow) + (HW + 1)'(r_i);
        csum  = (WW + 1)'(r_ocol) + (WW + 1)'(r_j);
        tap_ok = (rsum >= (HW + 1)'(r_eff)) && (rsum < (HW + 1)'(h_eff) + (HW + 1)'(r_eff))
              && (csum >= (WW + 1)'(r_eff)) && (csum < (WW + 1)'(w_eff) + (WW + 1)'(r_eff));
        t_row = BMW'(r_orow_mod) + BMW'(r_i);
        if (t_row >= BMW'(r_eff)) begin
            t_rowm = t_row - BMW'(r_eff);
        end else begin
            t_rowm = t_row + BMW'(BUF_ROWS) - BMW'(r_eff);
        end
        if (t_rowm >= BMW'(BUF_ROWS)) begin
            t_rowm = t_rowm - BMW'(BUF_ROWS);
        end
        cc       = CW'(csum - (WW + 1)'(r_eff));
        ls_raddr = LAW'(t_rowm) * LAW'(MAX_WIDTH) + LAW'(cc);
        tap_last = (r_i == side - KW'(1)) && (r_j == side - KW'(1));
    end

    // line store: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (ls_we) begin
            line_mem[ls_waddr] <= ls_wdata;
        end
        r_ls_q <= line_mem[ls_raddr];
    end

    // kernel table: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (k_we) begin
            kern_mem[k_waddr] <= r_coef;
        end
        r_k_q <= kern_mem[r_tap];
    end

    // multiply, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= (r_state == spc2d_pkg::S_MAC) && tap_ok;
        end
        r_prod <= r_va ? (32'(r_ls_q) * 32'(r_k_q)) : 32'sd0;
        if (r_state == spc2d_pkg::S_WRITE) begin
            r_acc <= '0;
        end else begin
            r_acc <= r_acc + spc2d_pkg::SUM_W'(r_prod);
        end
    end

    assign out_take = r_out_valid && !i_out_stall;
    assign out_load = (r_state == spc2d_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spc2d_pkg::S_CLEAR: begin
                if (r_clr == LAW'(LD - 1)) n_state = spc2d_pkg::S_IDLE;
            end
            spc2d_pkg::S_IDLE: begin
                if (i_in_valid) n_state = spc2d_pkg::S_WRITE;
            end
            spc2d_pkg::S_WRITE: begin
                if (((r_op == spc2d_pkg::OP_PIXEL) || (r_op == spc2d_pkg::OP_DRAIN)) && emit) begin
                    n_state = spc2d_pkg::S_MAC;
                end else begin
                    n_state = spc2d_pkg::S_IDLE;
                end
            end
            spc2d_pkg::S_MAC: begin
                if (tap_last) n_state = spc2d_pkg::S_FL1;
            end
            spc2d_pkg::S_FL1: n_state = spc2d_pkg::S_FL2;
            spc2d_pkg::S_FL2: n_state = spc2d_pkg::S_DONE;
            spc2d_pkg::S_DONE: begin
                if (out_load) n_state = spc2d_pkg::S_IDLE;
            end
            default: n_state = spc2d_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_stall   = (r_state != spc2d_pkg::S_IDLE);
        o_cfg_ready  = 1'b1;
        o_out_valid  = r_out_valid;
        o_sum_value  = r_sum;
        o_frame_last = r_flast;
    end

    // state, positions and window walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spc2d_pkg::S_CLEAR;
            r_clr      <= '0;
            r_pos      <= '0;
            r_in_col   <= '0;
            r_row_mod  <= '0;
            r_orow     <= '0;
            r_ocol     <= '0;
            r_orow_mod <= '0;
            r_last     <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_tap      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == spc2d_pkg::S_CLEAR) begin
                r_clr <= r_clr + LAW'(1);
            end
            if (cfg_hit) begin
                // a write to the width, height or radius register restarts the frame
                r_pos      <= '0;
                r_in_col   <= '0;
                r_row_mod  <= '0;
                r_orow     <= '0;
                r_ocol     <= '0;
                r_orow_mod <= '0;
            end else if ((r_state == spc2d_pkg::S_WRITE)
                    && ((r_op == spc2d_pkg::OP_PIXEL) || (r_op == spc2d_pkg::OP_DRAIN))) begin
                r_i    <= '0;
                r_j    <= '0;
                r_tap  <= '0;
                r_last <= emit && is_last;
                if (emit && is_last) begin
                    r_pos     <= '0;
                    r_in_col  <= '0;
                    r_row_mod <= '0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                    if ((WW)'(r_in_col) + WW'(1) >= w_eff) begin
                        r_in_col  <= '0;
                        r_row_mod <= (r_row_mod == BRW'(BUF_ROWS - 1)) ? '0
                                     : r_row_mod + BRW'(1);
                    end else begin
                        r_in_col <= r_in_col + CW'(1);
                    end
                end
            end else if (r_state == spc2d_pkg::S_MAC) begin
                r_tap <= r_tap + KAW'(1);
                if (r_j == side - KW'(1)) begin
                    r_j <= '0;
                    r_i <= r_i + KW'(1);
                end else begin
                    r_j <= r_j + KW'(1);
                end
            end else if (out_load) begin
                // advance the output position
                if (r_last) begin
                    r_orow     <= '0;
                    r_ocol     <= '0;
                    r_orow_mod <= '0;
                end else if (WW'(r_ocol) + WW'(1) >= w_eff) begin
                    r_ocol     <= '0;
                    r_orow     <= r_orow + HW'(1);
                    r_orow_mod <= (r_orow_mod == BRW'(BUF_ROWS - 1)) ? '0
                                  : r_orow_mod + BRW'(1);
                end else begin
                    r_ocol <= r_ocol + CW'(1);
                end
            end
        end
    end

    // latch the accepted request
    always_ff @(posedge i_clk) begin
        if ((r_state == spc2d_pkg::S_IDLE) && i_in_valid) begin
            r_op   <= i_op;
            r_pix  <= i_pixel_value;
            r_cidx <= i_coef_index;
            r_coef <= i_coef_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_sum   <= r_acc;
            r_flast <= r_last;
        end
    end

`ifndef SYNTHESIS
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spc2d_pkg::S_DONE && r_out_valid && i_out_stall)
        |=> r_state == spc2d_pkg::S_DONE)
        else $error("finished result left DONE while output was blocked");
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spc2d_pkg::S_MAC) |-> (r_i < side && r_j < side))
        else $error("window walk beyond kernel side");
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spc2d_pkg::S_CLEAR) |-> (o_in_stall && !k_we))
        else $error("request taken during clearing pass");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("output load lost");
`endif

endmodule
